// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the RTL file of the frame index mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FIEM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FIEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- rtl/core/fiem_pkg.sv -----
// Package with the register map, mode codes and fixed field widths of the frame index mapper.
package fiem_pkg;

    localparam int FRAME_W  = 32;
    localparam int COUNT_W  = 17;
    localparam int MODE_W   = 2;
    localparam int IDX_W    = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;
    localparam int DIST_W   = FRAME_W + 1;
    localparam int DVD_W    = FRAME_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE     = 2'd0,
        MODE_REPEAT   = 2'd1,
        MODE_PINGPONG = 2'd2,
        MODE_HOLD     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_OFFSET = 2'd0,
        REG_COUNT  = 2'd1,
        REG_BEFORE = 2'd2,
        REG_AFTER  = 2'd3
    } reg_idx_t;

endpackage

// ----- rtl/core/frame_index_extrapolation_mapper.sv -----
// Frame index mapper: a signed timeline frame becomes an index into a layer's stored frames.
//
// The block accepts one frame request per cycle unless a stall holds it, and returns one
// result for each, in order. A request passes through 36 register stages: the distance to the
// first stored frame, the window and mode decision, 32 remainder stages that each resolve one
// bit of the distance modulo the frame count or the ping-pong cycle, the sign correction, and
// the output register with the ping-pong fold. Stalls collapse bubbles stage by stage, so input
// transfers continue while a finished result waits. Configuration is written over the APB port
// while no request is in flight; the user must keep to this, the block itself does not enforce it.
`include "assert_macros.svh"

module frame_index_extrapolation_mapper #(
    parameter int MAX_FRAMES = 65536
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [fiem_pkg::FRAME_W-1:0]    s_frame_number,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic        [fiem_pkg::IDX_W-1:0]      m_stored_index,
    output logic                                   m_is_empty,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic        [fiem_pkg::ADDR_W-1:0]     paddr,
    input  logic        [fiem_pkg::DATA_W-1:0]     pwdata,
    output logic        [fiem_pkg::DATA_W-1:0]     prdata,
    output logic                                   pready
);

    localparam int CW   = $clog2(MAX_FRAMES + 1);
    localparam int CMPW = (CW > fiem_pkg::COUNT_W) ? CW : fiem_pkg::COUNT_W;
    localparam int DW   = CW + 1;
    localparam int NDIV = fiem_pkg::DVD_W;

    typedef struct packed {
        logic                          empty;
        logic                          use_mod;
        logic                          fold;
        logic                          neg;
        logic [fiem_pkg::IDX_W-1:0]    val;
        logic [DW-1:0]                 dvs;
    } ctl_t;

    typedef struct packed {
        ctl_t                          ctl;
        logic [fiem_pkg::DVD_W-1:0]    dvd;
        logic [DW-1:0]                 rem;
    } div_stage_t;

    typedef struct packed {
        ctl_t                          ctl;
        logic [DW-1:0]                 rem;
    } fix_stage_t;

    // Configuration registers.
    logic signed [fiem_pkg::FRAME_W-1:0] offset_reg;
    logic        [fiem_pkg::COUNT_W-1:0] frame_count_reg;
    fiem_pkg::mode_t                     before_mode_reg;
    fiem_pkg::mode_t                     after_mode_reg;
    fiem_pkg::reg_idx_t                  reg_sel;
    logic                                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = fiem_pkg::reg_idx_t'(paddr[fiem_pkg::ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg      <= '0;
            frame_count_reg <= '0;
            before_mode_reg <= fiem_pkg::MODE_NONE;
            after_mode_reg  <= fiem_pkg::MODE_NONE;
        end else if (cfg_write) begin
            case (reg_sel)
                fiem_pkg::REG_OFFSET: begin
                    offset_reg <= pwdata;
                end
                fiem_pkg::REG_COUNT: begin
                    frame_count_reg <= pwdata[fiem_pkg::COUNT_W-1:0];
                end
                fiem_pkg::REG_BEFORE: begin
                    before_mode_reg <= fiem_pkg::mode_t'(pwdata[fiem_pkg::MODE_W-1:0]);
                end
                fiem_pkg::REG_AFTER: begin
                    after_mode_reg <= fiem_pkg::mode_t'(pwdata[fiem_pkg::MODE_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            fiem_pkg::REG_OFFSET: prdata = offset_reg;
            fiem_pkg::REG_COUNT:  prdata = fiem_pkg::DATA_W'(frame_count_reg);
            fiem_pkg::REG_BEFORE: prdata = fiem_pkg::DATA_W'(before_mode_reg);
            fiem_pkg::REG_AFTER:  prdata = fiem_pkg::DATA_W'(after_mode_reg);
            default:              prdata = '0;
        endcase
    end

    // Frame count limited to the supported maximum, and values derived from it.
    logic [CMPW-1:0] count_ext;
    logic [CMPW-1:0] max_ext;
    logic [CW-1:0]   cnt;
    logic [CW-1:0]   cnt_m1;
    logic [DW-1:0]   cycle_len;

    assign count_ext = CMPW'(frame_count_reg);
    assign max_ext   = CMPW'(MAX_FRAMES);
    assign cnt       = (count_ext > max_ext) ? CW'(max_ext) : CW'(count_ext);
    assign cnt_m1    = cnt - CW'(1);
    assign cycle_len = {cnt_m1, 1'b0};

    // Stage A: distance from the first stored frame.
    logic                                a_valid_reg;
    logic [fiem_pkg::DIST_W-1:0]         a_dist_reg;
    logic [fiem_pkg::DIST_W-1:0]         a_dist_next;
    logic                                a_ready;

    logic                                div_valid_reg [0:NDIV];
    div_stage_t                          div_reg       [0:NDIV];
    div_stage_t                          div_next      [0:NDIV];
    logic                                div_ready     [0:NDIV];

    logic                                c_valid_reg;
    fix_stage_t                          c_reg;
    fix_stage_t                          c_next;
    logic                                c_ready;

    logic                                o_valid_reg;
    logic [fiem_pkg::IDX_W-1:0]          o_index_reg;
    logic [fiem_pkg::IDX_W-1:0]          o_index_next;
    logic                                o_empty_reg;
    logic                                o_ready;

    assign o_ready = !o_valid_reg || m_ready;
    assign c_ready = !c_valid_reg || o_ready;
    assign a_ready = !a_valid_reg || div_ready[0];
    assign s_ready = a_ready;

    assign a_dist_next = {s_frame_number[fiem_pkg::FRAME_W-1], s_frame_number}
                       - {offset_reg[fiem_pkg::FRAME_W-1], offset_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_valid;
        end
        if (a_ready) begin
            a_dist_reg <= a_dist_next;
        end
    end

    // Stage B: window test, mode selection and magnitude of the distance.
    logic                                b_neg;
    logic                                b_after;
    logic [fiem_pkg::DIST_W-1:0]         b_mag;
    fiem_pkg::mode_t                     b_mode;

    assign b_neg   = a_dist_reg[fiem_pkg::DIST_W-1];
    assign b_after = !b_neg && (a_dist_reg[fiem_pkg::DVD_W-1:0] >= fiem_pkg::DVD_W'(cnt));
    assign b_mag   = b_neg ? (fiem_pkg::DIST_W'(0) - a_dist_reg) : a_dist_reg;
    assign b_mode  = b_neg ? before_mode_reg : after_mode_reg;

    always_comb begin
        div_next[0]             = '0;
        div_next[0].dvd         = b_mag[fiem_pkg::DVD_W-1:0];
        div_next[0].ctl.neg     = b_neg;
        div_next[0].ctl.val     = a_dist_reg[fiem_pkg::IDX_W-1:0];
        if (cnt == '0) begin
            div_next[0].ctl.empty = 1'b1;
        end else if (b_neg || b_after) begin
            case (b_mode)
                fiem_pkg::MODE_NONE: begin
                    div_next[0].ctl.empty = 1'b1;
                end
                fiem_pkg::MODE_REPEAT: begin
                    div_next[0].ctl.use_mod = 1'b1;
                    div_next[0].ctl.dvs     = DW'(cnt);
                end
                fiem_pkg::MODE_PINGPONG: begin
                    if (cnt == CW'(1)) begin
                        div_next[0].ctl.val = '0;
                    end else begin
                        div_next[0].ctl.use_mod = 1'b1;
                        div_next[0].ctl.fold    = 1'b1;
                        div_next[0].ctl.dvs     = cycle_len;
                    end
                end
                fiem_pkg::MODE_HOLD: begin
                    div_next[0].ctl.val = b_neg ? '0 : fiem_pkg::IDX_W'(cnt_m1);
                end
                default: begin
                    div_next[0].ctl.empty = 1'b1;
                end
            endcase
        end
    end

    assign div_ready[0]    = !div_valid_reg[0] || div_ready[1];
    assign div_ready[NDIV] = !div_valid_reg[NDIV] || c_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_valid_reg[0] <= 1'b0;
        end else if (div_ready[0]) begin
            div_valid_reg[0] <= a_valid_reg;
        end
        if (div_ready[0]) begin
            div_reg[0] <= div_next[0];
        end
    end

    // Remainder stages: each shifts in one bit of the magnitude and subtracts the divisor when it fits.
    for (genvar k = 1; k <= NDIV; k++) begin : g_rem
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        fits;

        if (k < NDIV) begin : g_rdy
            assign div_ready[k] = !div_valid_reg[k] || div_ready[k+1];
        end

        assign trial = {div_reg[k-1].rem, div_reg[k-1].dvd[fiem_pkg::DVD_W-1]};
        assign diff  = trial - {1'b0, div_reg[k-1].ctl.dvs};
        assign fits  = trial >= {1'b0, div_reg[k-1].ctl.dvs};

        always_comb begin
            div_next[k]     = div_reg[k-1];
            div_next[k].dvd = {div_reg[k-1].dvd[fiem_pkg::DVD_W-2:0], 1'b0};
            div_next[k].rem = fits ? diff[DW-1:0] : trial[DW-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_valid_reg[k] <= 1'b0;
            end else if (div_ready[k]) begin
                div_valid_reg[k] <= div_valid_reg[k-1];
            end
            if (div_ready[k]) begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // Stage C: a negative distance turns its remainder into the non-negative one.
    always_comb begin
        c_next.ctl = div_reg[NDIV].ctl;
        c_next.rem = div_reg[NDIV].rem;
        if (div_reg[NDIV].ctl.neg && (div_reg[NDIV].rem != '0)) begin
            c_next.rem = div_reg[NDIV].ctl.dvs - div_reg[NDIV].rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ready) begin
            c_valid_reg <= div_valid_reg[NDIV];
        end
        if (c_ready) begin
            c_reg <= c_next;
        end
    end

    // Output stage: ping-pong fold and final selection.
    always_comb begin
        if (c_reg.ctl.empty) begin
            o_index_next = '0;
        end else if (!c_reg.ctl.use_mod) begin
            o_index_next = c_reg.ctl.val;
        end else if (c_reg.ctl.fold && (c_reg.rem >= DW'(cnt))) begin
            o_index_next = fiem_pkg::IDX_W'(c_reg.ctl.dvs - c_reg.rem);
        end else begin
            o_index_next = fiem_pkg::IDX_W'(c_reg.rem);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (o_ready) begin
            o_valid_reg <= c_valid_reg;
        end
        if (o_ready) begin
            o_index_reg <= o_index_next;
            o_empty_reg <= c_reg.ctl.empty;
        end
    end

    assign m_valid        = o_valid_reg;
    assign m_stored_index = o_index_reg;
    assign m_is_empty     = o_empty_reg;

    `FIEM_ASSERT_SAME(a_empty_zero, aclk, aresetn, m_valid && m_is_empty, m_stored_index == '0)
    `FIEM_ASSERT_SAME(a_mod_below_dvs, aclk, aresetn, c_valid_reg && c_reg.ctl.use_mod, c_reg.rem < c_reg.ctl.dvs)
    `FIEM_ASSERT_SAME(a_index_in_list, aclk, aresetn, m_valid && !m_is_empty, 32'(m_stored_index) < 32'(cnt))
    `FIEM_ASSERT_NEXT(a_rem_stall_hold, aclk, aresetn, div_valid_reg[NDIV] && !c_ready, div_valid_reg[NDIV] && $stable(div_reg[NDIV].rem))

endmodule

// ----- verif/frame_index_extrapolation_mapper_test.sv -----
// Self-checking testbench that maps directed and random frame requests in a local model and compares every result.
module frame_index_extrapolation_mapper_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FRAMES        = 65536;
    localparam int CLK_PERIOD        = 20;
    localparam int RESET_CYCLES      = 12;
    localparam int DRAIN_CYCLES      = 40;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int RANDOM_SETTINGS   = 30;
    localparam int ITEMS_PER_SETTING = 50;

    typedef struct packed {
        logic [fiem_pkg::IDX_W-1:0] stored_index;
        logic                       is_empty;
    } frame_map_t;

    logic                                aclk           = 1'b0;
    logic                                aresetn        = 1'b0;
    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic signed [fiem_pkg::FRAME_W-1:0] s_frame_number = '0;
    logic                                m_valid;
    logic                                m_ready        = 1'b0;
    logic [fiem_pkg::IDX_W-1:0]          m_stored_index;
    logic                                m_is_empty;
    logic                                psel           = 1'b0;
    logic                                penable        = 1'b0;
    logic                                pwrite         = 1'b0;
    logic [fiem_pkg::ADDR_W-1:0]         paddr          = '0;
    logic [fiem_pkg::DATA_W-1:0]         pwdata         = '0;
    logic [fiem_pkg::DATA_W-1:0]         prdata;
    logic                                pready;

    logic signed [fiem_pkg::FRAME_W-1:0] cfg_offset = '0;
    logic [fiem_pkg::COUNT_W-1:0]        cfg_count  = '0;
    fiem_pkg::mode_t                     cfg_before = fiem_pkg::MODE_NONE;
    fiem_pkg::mode_t                     cfg_after  = fiem_pkg::MODE_NONE;

    logic signed [fiem_pkg::FRAME_W-1:0] frame_backlog[$];
    frame_map_t                          due_results[$];
    frame_map_t                          result_want;
    int                                  sender_idle_pct   = 35;
    int                                  receiver_idle_pct = 45;
    bit                                  sender_hold       = 1'b0;
    int                                  mismatches        = 0;
    int                                  frames_sent       = 0;
    int                                  results_checked   = 0;
    int                                  empties_checked   = 0;
    int                                  settings_applied  = 0;
    longint                              cycle_count       = 0;

    frame_index_extrapolation_mapper #(
        .MAX_FRAMES(MAX_FRAMES)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frame_number(s_frame_number),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_stored_index(m_stored_index),
        .m_is_empty    (m_is_empty),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic longint wrap_mod(longint value, longint modulus);
        longint rem;
        rem = value % modulus;
        if (rem < 0) begin
            rem += modulus;
        end
        return rem;
    endfunction

    function automatic frame_map_t map_frame(logic signed [fiem_pkg::FRAME_W-1:0] frame);
        longint          distance;
        longint          cnt;
        longint          cyc;
        longint          folded;
        longint          idx;
        fiem_pkg::mode_t mode;
        bit              shown;
        bit              past_end;
        frame_map_t      res;
        cnt = longint'(cfg_count);
        if (cnt > MAX_FRAMES) begin
            cnt = MAX_FRAMES;
        end
        distance = longint'(frame) - longint'(cfg_offset);
        idx      = 0;
        shown    = 1'b1;
        if (cnt == 0) begin
            shown = 1'b0;
        end else if (distance >= 0 && distance < cnt) begin
            idx = distance;
        end else begin
            past_end = (distance >= cnt);
            mode     = past_end ? cfg_after : cfg_before;
            case (mode)
                fiem_pkg::MODE_REPEAT: begin
                    idx = wrap_mod(distance, cnt);
                end
                fiem_pkg::MODE_PINGPONG: begin
                    if (cnt == 1) begin
                        idx = 0;
                    end else if (cnt == 2) begin
                        idx = wrap_mod(distance, 2);
                    end else begin
                        cyc    = 2 * cnt - 2;
                        folded = wrap_mod(distance, cyc);
                        idx    = (folded >= cnt) ? cyc - folded : folded;
                    end
                end
                fiem_pkg::MODE_HOLD: begin
                    idx = past_end ? cnt - 1 : 0;
                end
                default: begin
                    shown = 1'b0;
                end
            endcase
        end
        if (!shown) begin
            idx = 0;
        end
        res.stored_index = idx[fiem_pkg::IDX_W-1:0];
        res.is_empty     = !shown;
        return res;
    endfunction

    function automatic logic signed [fiem_pkg::FRAME_W-1:0] pick_frame();
        longint span;
        longint base;
        span = longint'(cfg_count) * 3 + 4;
        if (span > 300000) begin
            span = 300000;
        end
        base = longint'(cfg_offset);
        case ($urandom_range(9))
            0, 1: begin
                return $urandom;
            end
            2: begin
                case ($urandom_range(5))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return fiem_pkg::FRAME_W'(base);
                    3: return fiem_pkg::FRAME_W'(base - 1);
                    4: return fiem_pkg::FRAME_W'(base + longint'(cfg_count) - 1);
                    default: return fiem_pkg::FRAME_W'(base + longint'(cfg_count));
                endcase
            end
            default: begin
                return fiem_pkg::FRAME_W'(base + longint'($urandom_range(int'(2 * span))) - span);
            end
        endcase
    endfunction

    function automatic void queue_frame(logic signed [fiem_pkg::FRAME_W-1:0] frame);
        frame_backlog.insert(frame_backlog.size(), frame);
    endfunction

    // The register takes the value at the access-phase edge.
    task automatic write_register(fiem_pkg::reg_idx_t which,
                                  logic [fiem_pkg::DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (which)
            fiem_pkg::REG_OFFSET: cfg_offset = value;
            fiem_pkg::REG_COUNT:  cfg_count  = value[fiem_pkg::COUNT_W-1:0];
            fiem_pkg::REG_BEFORE: cfg_before = fiem_pkg::mode_t'(value[fiem_pkg::MODE_W-1:0]);
            default:              cfg_after  = fiem_pkg::mode_t'(value[fiem_pkg::MODE_W-1:0]);
        endcase
    endtask

    task automatic apply_setting(logic [fiem_pkg::DATA_W-1:0] offset,
                                 logic [fiem_pkg::DATA_W-1:0] count,
                                 fiem_pkg::mode_t before_m, fiem_pkg::mode_t after_m);
        write_register(fiem_pkg::REG_OFFSET, offset);
        write_register(fiem_pkg::REG_COUNT, count);
        write_register(fiem_pkg::REG_BEFORE, fiem_pkg::DATA_W'(before_m));
        write_register(fiem_pkg::REG_AFTER, fiem_pkg::DATA_W'(after_m));
        settings_applied++;
        @(negedge aclk);
    endtask

    task automatic apply_random_setting();
        logic [fiem_pkg::DATA_W-1:0] offset;
        logic [fiem_pkg::DATA_W-1:0] count;
        case ($urandom_range(5))
            0:       offset = 32'h8000_0000;
            1:       offset = 32'h7fff_ffff;
            2, 3:    offset = fiem_pkg::DATA_W'($urandom_range(200)) - 100;
            default: offset = $urandom;
        endcase
        case ($urandom_range(9))
            0:       count = 0;
            1:       count = 1;
            2:       count = 2;
            3:       count = MAX_FRAMES;
            4:       count = $urandom_range(131071, MAX_FRAMES + 1);
            5:       count = $urandom_range(MAX_FRAMES - 1, 3);
            default: count = $urandom_range(40, 3);
        endcase
        apply_setting(offset, count, fiem_pkg::mode_t'($urandom_range(3)),
                      fiem_pkg::mode_t'($urandom_range(3)));
    endtask

    task automatic wait_quiet();
        @(negedge aclk);
        while (frame_backlog.size() > 0 || s_valid || due_results.size() > 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        sender_hold = 1'b1;
        while (s_valid || due_results.size() > 0) begin
            @(negedge aclk);
        end
        sender_hold = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                due_results.insert(due_results.size(), map_frame(s_frame_number));
                frames_sent++;
            end
            if (!s_valid || s_ready) begin
                if (frame_backlog.size() > 0 && !sender_hold &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    s_valid        <= 1'b1;
                    s_frame_number <= frame_backlog.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with nothing outstanding: stored_index %0d is_empty %0b",
                           m_stored_index, m_is_empty);
                    mismatches++;
                end else begin
                    result_want = due_results.pop_front();
                    results_checked++;
                    if (result_want.is_empty) begin
                        empties_checked++;
                    end
                    if (m_stored_index !== result_want.stored_index) begin
                        $error("stored_index: expected %0d, actual %0d",
                               result_want.stored_index, m_stored_index);
                        mismatches++;
                    end
                    if (m_is_empty !== result_want.is_empty) begin
                        $error("is_empty: expected %0b, actual %0b",
                               result_want.is_empty, m_is_empty);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        apply_setting(32'd10, 32'd4, fiem_pkg::MODE_REPEAT, fiem_pkg::MODE_PINGPONG);
        queue_frame(32'sd10);
        queue_frame(32'sd13);
        queue_frame(32'sd9);
        queue_frame(32'sd14);
        queue_frame(32'sd5);
        queue_frame(32'sh8000_0000);
        queue_frame(32'sh7fff_ffff);
        wait_quiet();

        apply_setting(32'd0, 32'd1, fiem_pkg::MODE_PINGPONG, fiem_pkg::MODE_NONE);
        queue_frame(-32'sd1);
        queue_frame(32'sh8000_0000);
        queue_frame(32'sd0);
        queue_frame(32'sd5);
        wait_quiet();

        apply_setting(32'h7fff_ffff, 32'd2, fiem_pkg::MODE_PINGPONG, fiem_pkg::MODE_NONE);
        queue_frame(32'sh8000_0000);
        queue_frame(32'sh7fff_fffe);
        queue_frame(32'sh7fff_ffff);
        wait_quiet();

        apply_setting(32'h8000_0000, MAX_FRAMES, fiem_pkg::MODE_NONE, fiem_pkg::MODE_REPEAT);
        queue_frame(32'sh7fff_ffff);
        queue_frame(32'sh8000_ffff);
        queue_frame(32'sh8001_0000);
        wait_quiet();

        apply_setting(32'd0, 32'd131071, fiem_pkg::MODE_NONE, fiem_pkg::MODE_HOLD);
        queue_frame(-32'sd7);
        queue_frame(32'sd65535);
        queue_frame(32'sd65536);
        wait_quiet();

        apply_setting(-32'sd3, 32'd6, fiem_pkg::MODE_HOLD, fiem_pkg::MODE_PINGPONG);
        queue_frame(-32'sd10);
        queue_frame(32'sd8);
        queue_frame(32'sd4);
        wait_quiet();

        apply_setting(32'd5, 32'd0, fiem_pkg::MODE_REPEAT, fiem_pkg::MODE_REPEAT);
        queue_frame(32'sd5);
        queue_frame(32'sd4);
        wait_quiet();

        for (int s = 0; s < RANDOM_SETTINGS; s++) begin
            if (s < RANDOM_SETTINGS / 3) begin
                sender_idle_pct   = 35;
                receiver_idle_pct = 45;
            end else if (s < 2 * RANDOM_SETTINGS / 3) begin
                sender_idle_pct   = 45;
                receiver_idle_pct = 35;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            apply_random_setting();
            for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
                queue_frame(pick_frame());
                if (s % 5 == 2 && i == ITEMS_PER_SETTING / 2) begin
                    while (frame_backlog.size() > 0) begin
                        @(negedge aclk);
                    end
                    hold_until_drained();
                end
            end
            wait_quiet();
        end

        $display("Checked %0d results from %0d frame transfers across %0d register settings.",
                 results_checked, frames_sent, settings_applied);
        $display("Of those results %0d were empty; modes on both sides were drawn at random.",
                 empties_checked);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
